### hw/rtl/jlss_pkg.sv
// Shared constants, request codes and types of the Jacobi solver.
// No dependencies; imported by the top level, jlss_div and jlss_checker.
package jlss_pkg;

  localparam int MAX_UNKNOWNS_DEF  = 32;
  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  localparam logic [1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [1:0] CFG_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_SIZE      = 2'd2;

  localparam logic [30:0] TOLERANCE_RESET = 31'd66;
  localparam logic [11:0] LIMIT_RESET     = 12'd2000;
  localparam logic [5:0]  SIZE_RESET      = 6'd4;

  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

endpackage

### hw/rtl/jacobi_linear_system_solver_unit.sv
// Jacobi iteration solver: load matrix and right-hand side, then solve on a start request.
// A load request writes its element and leaves the unit ready for the next request. A start
// request checks diagonal dominance, then, unless a pivot is zero, scales the rows through the
// shared bit-serial divider and iterates on the shared multiplier and adder until convergence
// or the step limit, then emits n results. No request is taken meanwhile.
// Depends on jlss_pkg, jlss_ram and jlss_div.
module jacobi_linear_system_solver_unit #(
  parameter int MAX_UNKNOWNS  = jlss_pkg::MAX_UNKNOWNS_DEF,
  parameter int VALUE_WIDTH   = jlss_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = jlss_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [4:0]         in_row_index,
  input  logic [4:0]         in_column_index,
  input  logic signed [31:0] in_element_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_unknown_index,
  output logic signed [31:0] out_unknown_value,
  output logic               out_last_unknown,
  output logic [11:0]        out_steps_taken,
  output logic               out_converged,
  output logic               out_diagonally_dominant,
  output logic               out_zero_pivot,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import jlss_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int AW = $clog2(MAX_UNKNOWNS);
  localparam int NW = $clog2(MAX_UNKNOWNS + 1);
  localparam int SW = W + AW + 1;
  localparam logic signed [W-1:0]  VMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  VMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [64:0]   VMAXE = 65'(VMAX);
  localparam logic signed [64:0]   VMINE = 65'(VMIN);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DOM_RD   = 5'd1;
  localparam logic [4:0] S_DOM_ACC  = 5'd2;
  localparam logic [4:0] S_DOM_ROW  = 5'd3;
  localparam logic [4:0] S_SC_PRD   = 5'd4;
  localparam logic [4:0] S_SC_PIV   = 5'd5;
  localparam logic [4:0] S_SC_BST   = 5'd6;
  localparam logic [4:0] S_SC_BW    = 5'd7;
  localparam logic [4:0] S_SC_ARD   = 5'd8;
  localparam logic [4:0] S_SC_AST   = 5'd9;
  localparam logic [4:0] S_SC_AW    = 5'd10;
  localparam logic [4:0] S_IT_CRD   = 5'd11;
  localparam logic [4:0] S_IT_C     = 5'd12;
  localparam logic [4:0] S_IT_RD    = 5'd13;
  localparam logic [4:0] S_IT_MUL   = 5'd14;
  localparam logic [4:0] S_IT_ADD   = 5'd15;
  localparam logic [4:0] S_IT_WR    = 5'd16;
  localparam logic [4:0] S_IT_END   = 5'd17;
  localparam logic [4:0] S_OUT_RD   = 5'd18;
  localparam logic [4:0] S_OUT_LD   = 5'd19;
  localparam logic [4:0] S_OUT_WAIT = 5'd20;

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] a);
    mag_f = a[W-1] ? W'(-a) : W'(a);
  endfunction

  function automatic logic signed [W-1:0] sat_add_f(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      sat_add_f = s[W] ? VMIN : VMAX;
    end else begin
      sat_add_f = s[W-1:0];
    end
  endfunction

  logic [4:0]          state_r;
  logic [30:0]         tol_r;
  logic [11:0]         lim_r;
  logic [5:0]          size_r;
  logic [AW-1:0]       i_r;
  logic [AW-1:0]       j_r;
  logic [NW-1:0]       n_r;
  logic                p_r;
  logic                dom_r;
  logic                pz_r;
  logic                conv_r;
  logic [11:0]         steps_r;
  logic [SW-1:0]       sum_r;
  logic [W-1:0]        dmag_r;
  logic                dzero_r;
  logic signed [W-1:0] piv_r;
  logic signed [W-1:0] acc_r;
  logic [2*W-1:0]      prod_r;
  logic                pneg_r;
  logic signed [W-1:0] prev_i_r;
  logic [W-1:0]        delta_r;
  logic                out_valid_r;
  logic [4:0]          out_idx_r;
  logic signed [31:0]  out_val_r;
  logic                out_last_r;

  logic signed [W-1:0] a_rd, b_rd, c_rd, s_rd, x_rd;
  logic                a_we, b_we, c_we, s_we, x_we;
  logic signed [W-1:0] s_wdata, x_wdata, load_v;
  logic [AW:0]         x_waddr, x_raddr;
  logic [2*AW-1:0]     a_raddr;
  div_req_t            div_req;
  logic [W-1:0]        div_num;
  logic                div_done;
  logic signed [W-1:0] div_q;

  logic                accept_nxt;
  logic                in_range_nxt;
  logic                last_i_nxt, last_j_nxt, diag_nxt;
  logic [7:0]          ss8_nxt;
  logic [NW-1:0]       n_nxt;
  logic signed [64:0]  ev_nxt, xe_nxt;
  logic [2*W-1:0]      pm_nxt;
  logic signed [W-1:0] pval_nxt;
  logic signed [W:0]   dd_nxt;
  logic [W:0]          am_nxt;
  logic [W-1:0]        d_nxt;
  logic [11:0]         steps_inc_nxt;

  always_comb begin
    accept_nxt   = in_valid && !in_stall;
    in_range_nxt = (8'(in_row_index) < 8'(MAX_UNKNOWNS)) &&
                   (8'(in_column_index) < 8'(MAX_UNKNOWNS));
    ev_nxt       = 65'(in_element_value);
    load_v       = (ev_nxt > VMAXE) ? VMAX : (ev_nxt < VMINE) ? VMIN : ev_nxt[W-1:0];
    last_i_nxt   = NW'(i_r) == n_r - NW'(1);
    last_j_nxt   = NW'(j_r) == n_r - NW'(1);
    diag_nxt     = i_r == j_r;
    ss8_nxt      = 8'(size_r);
    n_nxt        = (ss8_nxt == 8'd0) ? NW'(1) :
                   (ss8_nxt > 8'(MAX_UNKNOWNS)) ? NW'(MAX_UNKNOWNS) : NW'(ss8_nxt);
    pm_nxt       = prod_r >> FB;
    pval_nxt     = (|pm_nxt[2*W-1:W-1]) ? (pneg_r ? VMIN : VMAX)
                   : (pneg_r ? -signed'(pm_nxt[W-1:0]) : signed'(pm_nxt[W-1:0]));
    dd_nxt       = {acc_r[W-1], acc_r} - {prev_i_r[W-1], prev_i_r};
    am_nxt       = dd_nxt[W] ? (W+1)'(-dd_nxt) : (W+1)'(dd_nxt);
    d_nxt        = (am_nxt > (W+1)'(VMAX)) ? W'(VMAX) : am_nxt[W-1:0];
    xe_nxt       = pz_r ? 65'sd0 : 65'(x_rd);
    steps_inc_nxt = steps_r + 12'd1;

    a_we    = accept_nxt && in_opcode == OP_LOAD_A && in_range_nxt;
    b_we    = accept_nxt && in_opcode == OP_LOAD_B && (8'(in_row_index) < 8'(MAX_UNKNOWNS));
    a_raddr = (state_r == S_SC_PRD) ? {i_r, i_r} : {i_r, j_r};
    c_we    = state_r == S_SC_BW && div_done;
    s_we    = (state_r == S_SC_AST && diag_nxt) || (state_r == S_SC_AW && div_done);
    s_wdata = (state_r == S_SC_AST) ? '0 : div_q;
    x_we    = c_we || state_r == S_IT_WR;
    x_waddr = (state_r == S_IT_WR) ? {!p_r, i_r} : {p_r, i_r};
    x_wdata = (state_r == S_IT_WR) ? acc_r : div_q;
    x_raddr = (state_r == S_OUT_RD) ? {p_r, i_r} : {p_r, j_r};

    div_req.start = state_r == S_SC_BST || (state_r == S_SC_AST && !diag_nxt);
    div_req.neg   = (state_r == S_SC_BST) ? (b_rd[W-1] != piv_r[W-1])
                                          : (a_rd[W-1] == piv_r[W-1]);
    div_num       = (state_r == S_SC_BST) ? mag_f(b_rd) : mag_f(a_rd);
  end

  jlss_ram #(.WIDTH(W), .DEPTH(1 << (2 * AW))) u_a_ram (
    .clk(clk), .we(a_we), .waddr({AW'(in_row_index), AW'(in_column_index)}),
    .wdata(load_v), .raddr(a_raddr), .rdata(a_rd)
  );

  jlss_ram #(.WIDTH(W), .DEPTH(1 << AW)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(AW'(in_row_index)), .wdata(load_v),
    .raddr(i_r), .rdata(b_rd)
  );

  jlss_ram #(.WIDTH(W), .DEPTH(1 << AW)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(i_r), .wdata(div_q), .raddr(i_r), .rdata(c_rd)
  );

  jlss_ram #(.WIDTH(W), .DEPTH(1 << (2 * AW))) u_s_ram (
    .clk(clk), .we(s_we), .waddr({i_r, j_r}), .wdata(s_wdata),
    .raddr({i_r, j_r}), .rdata(s_rd)
  );

  jlss_ram #(.WIDTH(W), .DEPTH(2 << AW)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rd)
  );

  jlss_div #(.W(W), .FB(FB)) u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .num_mag(div_num),
    .den_mag(mag_f(piv_r)), .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= TOLERANCE_RESET;
      lim_r       <= LIMIT_RESET;
      size_r      <= SIZE_RESET;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TOLERANCE: tol_r  <= cfg_data[30:0];
          CFG_LIMIT:     lim_r  <= cfg_data[11:0];
          CFG_SIZE:      size_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept_nxt && in_opcode == OP_START) begin
            n_r     <= n_nxt;
            i_r     <= '0;
            j_r     <= '0;
            sum_r   <= '0;
            dom_r   <= 1'b1;
            pz_r    <= 1'b0;
            conv_r  <= 1'b0;
            p_r     <= 1'b0;
            state_r <= S_DOM_RD;
          end
        end
        S_DOM_RD: state_r <= S_DOM_ACC;
        S_DOM_ACC: begin
          if (diag_nxt) begin
            dmag_r  <= mag_f(a_rd);
            dzero_r <= a_rd == '0;
          end else begin
            sum_r <= sum_r + SW'(mag_f(a_rd));
          end
          if (last_j_nxt) begin
            state_r <= S_DOM_ROW;
          end else begin
            j_r     <= j_r + AW'(1);
            state_r <= S_DOM_RD;
          end
        end
        S_DOM_ROW: begin
          if (SW'(dmag_r) < sum_r) begin
            dom_r <= 1'b0;
          end
          if (dzero_r) begin
            pz_r <= 1'b1;
          end
          sum_r <= '0;
          j_r   <= '0;
          if (last_i_nxt) begin
            i_r <= '0;
            if (pz_r || dzero_r) begin
              steps_r <= '0;
              state_r <= S_OUT_RD;
            end else begin
              state_r <= S_SC_PRD;
            end
          end else begin
            i_r     <= i_r + AW'(1);
            state_r <= S_DOM_RD;
          end
        end
        S_SC_PRD: state_r <= S_SC_PIV;
        S_SC_PIV: begin
          piv_r   <= a_rd;
          state_r <= S_SC_BST;
        end
        S_SC_BST: state_r <= S_SC_BW;
        S_SC_BW: begin
          if (div_done) begin
            j_r     <= '0;
            state_r <= S_SC_ARD;
          end
        end
        S_SC_ARD: state_r <= S_SC_AST;
        S_SC_AST, S_SC_AW: begin
          if ((state_r == S_SC_AST && diag_nxt) || (state_r == S_SC_AW && div_done)) begin
            if (last_j_nxt) begin
              j_r <= '0;
              if (last_i_nxt) begin
                i_r     <= '0;
                steps_r <= '0;
                delta_r <= '0;
                state_r <= S_IT_CRD;
              end else begin
                i_r     <= i_r + AW'(1);
                state_r <= S_SC_PRD;
              end
            end else begin
              j_r     <= j_r + AW'(1);
              state_r <= S_SC_ARD;
            end
          end else if (state_r == S_SC_AST) begin
            state_r <= S_SC_AW;
          end
        end
        S_IT_CRD: state_r <= S_IT_C;
        S_IT_C: begin
          acc_r   <= c_rd;
          j_r     <= '0;
          state_r <= S_IT_RD;
        end
        S_IT_RD: state_r <= S_IT_MUL;
        S_IT_MUL: begin
          prod_r <= (2*W)'(mag_f(s_rd)) * (2*W)'(mag_f(x_rd));
          pneg_r <= s_rd[W-1] != x_rd[W-1];
          if (diag_nxt) begin
            prev_i_r <= x_rd;
          end
          state_r <= S_IT_ADD;
        end
        S_IT_ADD: begin
          acc_r <= sat_add_f(acc_r, pval_nxt);
          if (last_j_nxt) begin
            state_r <= S_IT_WR;
          end else begin
            j_r     <= j_r + AW'(1);
            state_r <= S_IT_RD;
          end
        end
        S_IT_WR: begin
          if (d_nxt > delta_r) begin
            delta_r <= d_nxt;
          end
          if (last_i_nxt) begin
            state_r <= S_IT_END;
          end else begin
            i_r     <= i_r + AW'(1);
            state_r <= S_IT_CRD;
          end
        end
        S_IT_END: begin
          steps_r <= steps_inc_nxt;
          p_r     <= !p_r;
          i_r     <= '0;
          delta_r <= '0;
          if (65'(delta_r) < 65'(tol_r)) begin
            conv_r  <= 1'b1;
            state_r <= S_OUT_RD;
          end else if (steps_inc_nxt >= lim_r) begin
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_IT_CRD;
          end
        end
        S_OUT_RD: state_r <= S_OUT_LD;
        S_OUT_LD: begin
          out_idx_r   <= 5'(i_r);
          out_val_r   <= (xe_nxt > 65'sd2147483647) ? 32'sh7fffffff :
                         (xe_nxt < -65'sd2147483648) ? 32'sh80000000 : xe_nxt[31:0];
          out_last_r  <= last_i_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (last_i_nxt) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + AW'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall                = state_r != S_IDLE;
  assign cfg_ready               = 1'b1;
  assign out_valid               = out_valid_r;
  assign out_unknown_index       = out_idx_r;
  assign out_unknown_value       = out_val_r;
  assign out_last_unknown        = out_last_r;
  assign out_steps_taken         = steps_r;
  assign out_converged           = conv_r;
  assign out_diagonally_dominant = dom_r;
  assign out_zero_pivot          = pz_r;

endmodule

### hw/rtl/jlss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jlss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/jlss_div.sv
// Restoring fixed-point divider, one quotient bit per cycle, saturated result.
// Depends on jlss_pkg (div_req_t).
module jlss_div #(
  parameter int W  = 32,
  parameter int FB = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  jlss_pkg::div_req_t  req,
  input  logic [W-1:0]        num_mag,
  input  logic [W-1:0]        den_mag,
  output logic                done,
  output logic signed [W-1:0] quot
);
  import jlss_pkg::*;

  localparam int NB = W + FB;
  localparam int CW = $clog2(NB + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  den_r;
  logic [NB-1:0] num_r;
  logic [NB-1:0] quo_r;
  logic          neg_r;
  logic [W:0]    trial_nxt;
  logic          ge_nxt;
  logic [W-1:0]  rem_nxt;
  logic          ovf_nxt;

  always_comb begin
    trial_nxt = {rem_r, num_r[NB-1]};
    ge_nxt    = trial_nxt >= {1'b0, den_r};
    rem_nxt   = ge_nxt ? W'(trial_nxt - {1'b0, den_r}) : trial_nxt[W-1:0];
    ovf_nxt   = |quo_r[NB-1:W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NB);
        rem_r  <= '0;
        num_r  <= {num_mag, {FB{1'b0}}};
        den_r  <= den_mag;
        neg_r  <= req.neg;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= num_r << 1;
        quo_r <= {quo_r[NB-2:0], ge_nxt};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = ovf_nxt ? (neg_r ? VMIN : VMAX)
                        : (neg_r ? -signed'(quo_r[W-1:0]) : signed'(quo_r[W-1:0]));

endmodule

### hw/rtl/jlss_checker.sv
// Port-level checks of the Jacobi solver, bound to the top level.
// Depends on jlss_pkg (request codes).
module jlss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_opcode,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_last_unknown,
  input logic [31:0] out_unknown_value
);
  import jlss_pkg::*;

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while results pending");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode != OP_START) |=> !in_stall)
    else $error("load request did not finish in one cycle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_unknown) |=> !out_valid)
    else $error("result after last unknown");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_unknown_value)))
    else $error("stalled result changed");

endmodule

bind jacobi_linear_system_solver_unit jlss_checker u_jlss_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_opcode(in_opcode), .out_valid(out_valid), .out_stall(out_stall),
  .out_last_unknown(out_last_unknown), .out_unknown_value(out_unknown_value)
);
